/* src/stylesheet_token_parser_macros.svh */
// ----------------------------------------------------------------------------
// Style-sheet token parser assertion macros
// Shared concurrent assertion forms; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef STYLESHEET_TOKEN_PARSER_MACROS_SVH
`define STYLESHEET_TOKEN_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

`define STP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("stp: same-cycle check failed");

`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("stp: next-cycle check failed");

`else

`define STP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define STP_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/stp_pkg.sv */
// ----------------------------------------------------------------------------
// Style-sheet token parser package
// Result beat type, token and error codes, character constants.
// ----------------------------------------------------------------------------
package stp_pkg;

	localparam logic [2:0] KIND_SELECTOR = 3'd0;
	localparam logic [2:0] KIND_PROPERTY = 3'd1;
	localparam logic [2:0] KIND_VALUE    = 3'd2;
	localparam logic [2:0] KIND_RULE_END = 3'd3;
	localparam logic [2:0] KIND_DONE     = 3'd4;
	localparam logic [2:0] KIND_ERROR    = 3'd5;

	localparam logic [2:0] EXP_NONE     = 3'd0;
	localparam logic [2:0] EXP_SELECTOR = 3'd1;
	localparam logic [2:0] EXP_OPEN     = 3'd2;
	localparam logic [2:0] EXP_PROPERTY = 3'd3;
	localparam logic [2:0] EXP_COLON    = 3'd4;
	localparam logic [2:0] EXP_CLOSE    = 3'd5;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] token_start;
		logic [15:0] token_length;
		logic [2:0]  expected_what;
		logic [7:0]  got_byte;
		logic [15:0] error_line;
		logic [15:0] error_column;
		logic        last_of_run;
	} stp_result_t;

	typedef struct packed {
		stp_result_t res0;
		stp_result_t res1;
		logic [1:0]  count;
	} stp_step_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              room;
	} stp_queue_status_t;

	function automatic stp_result_t mk_token(logic [2:0] kind, logic [15:0] start,
			logic [15:0] len);
		stp_result_t r;
		r = '0;
		r.kind = kind;
		r.token_start = start;
		r.token_length = len;
		return r;
	endfunction

	function automatic stp_result_t mk_error(logic [2:0] exp, logic [7:0] got,
			logic [15:0] line, logic [15:0] col);
		stp_result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.expected_what = exp;
		r.got_byte = got;
		r.error_line = line;
		r.error_column = col;
		return r;
	endfunction

endpackage

/* src/stp_fsm.sv */
// ----------------------------------------------------------------------------
// Style-sheet token parser state machine
// Phase, offset, line and column registers and the per-byte token step.
// ----------------------------------------------------------------------------
module stp_fsm #(
	parameter longint unsigned MAX_TEXT_BYTES = 64'd65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         char_byte,
	input  logic               end_of_text,
	output stp_pkg::stp_step_t step_out
);
	import stp_pkg::*;

	localparam logic [15:0] POS_LIMIT = (MAX_TEXT_BYTES - 64'd1 > 64'd65535) ?
		16'hFFFF : 16'(MAX_TEXT_BYTES - 64'd1);

	localparam logic [3:0] PH_SHEET_WS   = 4'd0;
	localparam logic [3:0] PH_SELECTOR   = 4'd1;
	localparam logic [3:0] PH_AFTER_SEL  = 4'd2;
	localparam logic [3:0] PH_DECL_WS    = 4'd3;
	localparam logic [3:0] PH_PROPERTY   = 4'd4;
	localparam logic [3:0] PH_AFTER_PROP = 4'd5;
	localparam logic [3:0] PH_VALUE_WS   = 4'd6;
	localparam logic [3:0] PH_VALUE      = 4'd7;
	localparam logic [3:0] PH_HALT       = 4'd8;

	logic [3:0]  phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] begin_q, begin_d;
	logic [15:0] trim_q, trim_d;
	logic [15:0] line_q, line_d;
	logic [15:0] col_q, col_d;

	logic        fin, ws, brk;
	logic [15:0] nxt, tok_len, val_len;
	stp_result_t r0, r1;
	logic [1:0]  n;

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		begin_d = begin_q;
		trim_d = trim_q;
		line_d = line_q;
		col_d = col_q;
		r0 = '0;
		r1 = '0;
		n = 2'd0;
		fin = end_of_text || (char_byte == CH_NUL);
		brk = (char_byte == CH_SPACE) || (char_byte == CH_LF) || (char_byte == CH_TAB);
		ws = brk || (char_byte == CH_CR);
		nxt = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
		tok_len = pos_q - begin_q;
		val_len = (trim_q >= begin_q) ? trim_q - begin_q : 16'd0;
		if (phase_q == PH_HALT) begin
			if (end_of_text) begin
				phase_d = PH_SHEET_WS;
				pos_d = '0;
				begin_d = '0;
				trim_d = '0;
				line_d = '0;
				col_d = '0;
			end
		end else begin
			case (phase_q)
				PH_SHEET_WS: begin
					if (fin) begin
						r0 = mk_token(KIND_DONE, 16'd0, 16'd0);
						n = 2'd1;
					end else if (ws) begin
					end else if (char_byte == CH_LBRACE) begin
						r0 = mk_error(EXP_SELECTOR, char_byte, line_q, col_q);
						n = 2'd1;
						phase_d = PH_HALT;
					end else begin
						begin_d = pos_q;
						phase_d = PH_SELECTOR;
					end
				end
				PH_SELECTOR: begin
					r0 = mk_token(KIND_SELECTOR, begin_q, tok_len);
					if (fin) begin
						r1 = mk_error(EXP_OPEN, CH_NUL, line_q, col_q);
						n = 2'd2;
						phase_d = PH_HALT;
					end else if (char_byte == CH_LBRACE) begin
						n = 2'd1;
						phase_d = PH_DECL_WS;
					end else if (brk) begin
						n = 2'd1;
						phase_d = PH_AFTER_SEL;
					end
				end
				PH_AFTER_SEL: begin
					if (fin) begin
						r0 = mk_error(EXP_OPEN, CH_NUL, line_q, col_q);
						n = 2'd1;
						phase_d = PH_HALT;
					end else if (ws) begin
					end else if (char_byte == CH_LBRACE) begin
						phase_d = PH_DECL_WS;
					end else begin
						r0 = mk_error(EXP_OPEN, char_byte, line_q, col_q);
						n = 2'd1;
						phase_d = PH_HALT;
					end
				end
				PH_DECL_WS: begin
					if (fin) begin
						r0 = mk_error(EXP_CLOSE, CH_NUL, line_q, col_q);
						n = 2'd1;
						phase_d = PH_HALT;
					end else if (ws) begin
					end else if (char_byte == CH_RBRACE) begin
						r0 = mk_token(KIND_RULE_END, pos_q, 16'd1);
						n = 2'd1;
						phase_d = PH_SHEET_WS;
					end else if (char_byte == CH_COLON) begin
						r0 = mk_error(EXP_PROPERTY, char_byte, line_q, col_q);
						n = 2'd1;
						phase_d = PH_HALT;
					end else begin
						begin_d = pos_q;
						phase_d = PH_PROPERTY;
					end
				end
				PH_PROPERTY: begin
					r0 = mk_token(KIND_PROPERTY, begin_q, tok_len);
					if (fin) begin
						r1 = mk_error(EXP_COLON, CH_NUL, line_q, col_q);
						n = 2'd2;
						phase_d = PH_HALT;
					end else if (char_byte == CH_COLON) begin
						n = 2'd1;
						phase_d = PH_VALUE_WS;
					end else if (brk) begin
						n = 2'd1;
						phase_d = PH_AFTER_PROP;
					end else if (char_byte == CH_RBRACE) begin
						r1 = mk_error(EXP_COLON, char_byte, line_q, col_q);
						n = 2'd2;
						phase_d = PH_HALT;
					end
				end
				PH_AFTER_PROP: begin
					if (fin) begin
						r0 = mk_error(EXP_COLON, CH_NUL, line_q, col_q);
						n = 2'd1;
						phase_d = PH_HALT;
					end else if (ws) begin
					end else if (char_byte == CH_COLON) begin
						phase_d = PH_VALUE_WS;
					end else begin
						r0 = mk_error(EXP_COLON, char_byte, line_q, col_q);
						n = 2'd1;
						phase_d = PH_HALT;
					end
				end
				PH_VALUE_WS: begin
					r0 = mk_token(KIND_VALUE, pos_q, 16'd0);
					if (fin) begin
						r1 = mk_error(EXP_CLOSE, CH_NUL, line_q, col_q);
						n = 2'd2;
						phase_d = PH_HALT;
					end else if (ws) begin
					end else if (char_byte == CH_SEMI) begin
						n = 2'd1;
						phase_d = PH_DECL_WS;
					end else if (char_byte == CH_RBRACE) begin
						r1 = mk_token(KIND_RULE_END, pos_q, 16'd1);
						n = 2'd2;
						phase_d = PH_SHEET_WS;
					end else begin
						begin_d = pos_q;
						trim_d = nxt;
						phase_d = PH_VALUE;
					end
				end
				PH_VALUE: begin
					r0 = mk_token(KIND_VALUE, begin_q, val_len);
					if (fin) begin
						r1 = mk_error(EXP_CLOSE, CH_NUL, line_q, col_q);
						n = 2'd2;
						phase_d = PH_HALT;
					end else if (char_byte == CH_SEMI) begin
						n = 2'd1;
						phase_d = PH_DECL_WS;
					end else if (char_byte == CH_RBRACE) begin
						r1 = mk_token(KIND_RULE_END, pos_q, 16'd1);
						n = 2'd2;
						phase_d = PH_SHEET_WS;
					end else if (!ws) begin
						trim_d = nxt;
					end
				end
				default: begin
					phase_d = PH_HALT;
				end
			endcase
			if (end_of_text) begin
				phase_d = PH_SHEET_WS;
				pos_d = '0;
				begin_d = '0;
				trim_d = '0;
				line_d = '0;
				col_d = '0;
			end else if (char_byte == CH_NUL) begin
				phase_d = PH_HALT;
			end else begin
				if (pos_q < POS_LIMIT) begin
					pos_d = pos_q + 16'd1;
				end
				if (char_byte == CH_LF) begin
					if (line_q != 16'hFFFF) begin
						line_d = line_q + 16'd1;
					end
					col_d = '0;
				end else if (col_q != 16'hFFFF) begin
					col_d = col_q + 16'd1;
				end
			end
		end
		r0.last_of_run = (n == 2'd1);
		r1.last_of_run = 1'b1;
		step_out.res0 = r0;
		step_out.res1 = r1;
		step_out.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SHEET_WS;
			pos_q <= '0;
			begin_q <= '0;
			trim_q <= '0;
			line_q <= '0;
			col_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			begin_q <= begin_d;
			trim_q <= trim_d;
			line_q <= line_d;
			col_q <= col_d;
		end
	end

endmodule

/* src/stp_queue.sv */
// ----------------------------------------------------------------------------
// Style-sheet token parser result queue
// Four-entry result queue: up to two beats in per cycle, one beat out.
// ----------------------------------------------------------------------------
module stp_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	input  stp_pkg::stp_step_t         push,
	input  logic                       pop,
	output stp_pkg::stp_result_t       head,
	output logic                       head_valid,
	output stp_pkg::stp_queue_status_t status
);
	import stp_pkg::*;

	stp_result_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;
	logic [QPTR_W-1:0] wr_next;

	assign wr_next = wr_q + QPTR_W'(1);
	assign head = mem_q[rd_q];
	assign head_valid = (count_q != '0);
	assign status.count = count_q;
	assign status.room = (count_q <= QCNT_W'(2)) || ((count_q == QCNT_W'(3)) && pop);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.res0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + QPTR_W'(push.count);
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule

/* src/stylesheet_token_parser.sv */
// ----------------------------------------------------------------------------
// Style-sheet token parser
// Byte-serial ruleset tokenizer with error reporting.
// ----------------------------------------------------------------------------
// Input channel: one text byte per beat (char_byte, end_of_text) on
// byte_valid / byte_stall. A zero byte ends the text; an end_of_text beat
// ends it too and re-arms the parser for the next text.
// Output channel: one token or error record per beat on token_valid /
// token_stall; last_of_run flags the final record caused by an input beat.
// Each byte gives zero, one or two records.
// A byte lands in the input register, is parsed there once the queue has
// room, and its records enter the result queue, whose head drives the output.
// Throughput: one byte per cycle while records drain at least as fast as
// they are made; the one-record-per-cycle output port bounds the rate when
// many bytes give two records.
// Stall: records wait in a four-entry queue; byte_stall rises when a byte is
// held and the queue has no room for two records, even if that byte gives fewer.
// Reset: queue empty, parser at sheet start with offset, line and column
// at zero.
// ----------------------------------------------------------------------------
`include "stylesheet_token_parser_macros.svh"

module stylesheet_token_parser #(
	parameter longint unsigned MAX_TEXT_BYTES = 64'd65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  char_byte,
	input  logic        end_of_text,
	output logic        token_valid,
	input  logic        token_stall,
	output logic [2:0]  kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [2:0]  expected_what,
	output logic [7:0]  got_byte,
	output logic [15:0] error_line,
	output logic [15:0] error_column,
	output logic        last_of_run
);
	import stp_pkg::*;

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              eot_s1;
	logic              advance;
	logic              pop;
	stp_step_t         step_out;
	stp_step_t         push;
	stp_result_t       head;
	stp_queue_status_t q_status;

	assign pop = token_valid && !token_stall;
	assign advance = valid_s1 && q_status.room;
	assign byte_stall = valid_s1 && !q_status.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			char_s1 <= char_byte;
			eot_s1 <= end_of_text;
		end
	end

	stp_fsm #(
		.MAX_TEXT_BYTES(MAX_TEXT_BYTES)
	) u_fsm (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.char_byte(char_s1),
		.end_of_text(eot_s1),
		.step_out(step_out)
	);

	always_comb begin
		push = step_out;
		if (!advance) begin
			push.count = 2'd0;
		end
	end

	stp_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.head(head),
		.head_valid(token_valid),
		.status(q_status)
	);

	assign kind = head.kind;
	assign token_start = head.token_start;
	assign token_length = head.token_length;
	assign expected_what = head.expected_what;
	assign got_byte = head.got_byte;
	assign error_line = head.error_line;
	assign error_column = head.error_column;
	assign last_of_run = head.last_of_run;

	`STP_ASSERT_IMPLY(a_count_cap, clk, arst_n, 1'b1, q_status.count <= 3'd4)
	`STP_ASSERT_IMPLY(a_error_last, clk, arst_n, token_valid && (kind == KIND_ERROR), last_of_run)
	`STP_ASSERT_IMPLY(a_stall_backlog, clk, arst_n, byte_stall, q_status.count >= 3'd3)
	`STP_ASSERT_NEXT(a_idle_empty, clk, arst_n, !token_valid && !advance, !token_valid)

endmodule
